>>> rtl/htfd_pkg.sv
// Shared types, constants and the CRC-8 byte function of the frame decoder.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none

package htfd_pkg;

    // CRC-8 with polynomial x^8+x^5+x^4+1, seeded with all ones.
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Byte positions within one six-byte reply.
    localparam logic [2:0] POS_T_HIGH = 3'd0;
    localparam logic [2:0] POS_T_LOW  = 3'd1;
    localparam logic [2:0] POS_T_CRC  = 3'd2;
    localparam logic [2:0] POS_H_HIGH = 3'd3;
    localparam logic [2:0] POS_H_LOW  = 3'd4;
    localparam logic [2:0] POS_H_CRC  = 3'd5;

    // Kind of measurement carried by a result.
    localparam logic KIND_TEMP = 1'b0;
    localparam logic KIND_HUM  = 1'b1;

    // Scaling constants: value = span * raw / 65535, temperature less its offset.
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] HUM_SPAN    = 15'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [16:0] RAW_FULL    = 17'd65535;

    // Values reported when a word fails its checksum.
    localparam logic [15:0] TEMP_BAD = 16'h8000;
    localparam logic [15:0] HUM_BAD  = 16'hFFFF;

    // Queue between the byte front end and the scaling back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One complete word, ready for scaling.
    typedef struct packed {
        logic        kind;
        logic        ok;
        logic [15:0] raw;
    } t_job;

    // Advances the CRC over one byte, most significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/htfd_front.sv
// Front end of the frame decoder: tracks the byte position, runs the CRC and
// collects each word. Depends on htfd_pkg; feeds htfd_queue.
`default_nettype none

module htfd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_frame_start,
    input  wire logic          i_q_full,
    output logic               o_push,
    output htfd_pkg::t_job     o_job
);

    logic [2:0] r_pos, n_pos;
    logic [7:0] r_crc, n_crc;
    logic [7:0] r_high, n_high;
    logic [7:0] r_low, n_low;

    logic       accept;
    logic       restart;
    logic [2:0] pos_eff;
    logic [7:0] crc_eff;
    logic [7:0] crc_next;

    // A transaction is taken whenever the queue has room for a possible word.
    assign o_ready = ~i_q_full;
    assign accept  = i_valid & o_ready;

    // A frame marker or an unused position restarts the reply.
    assign restart  = i_frame_start | (r_pos > htfd_pkg::POS_H_CRC);
    assign pos_eff  = restart ? htfd_pkg::POS_T_HIGH : r_pos;
    assign crc_eff  = restart ? htfd_pkg::CRC_INIT : r_crc;
    assign crc_next = htfd_pkg::crc8_byte(crc_eff, i_data_byte);

    // The word handed on when the checksum byte arrives.
    assign o_job.kind = (pos_eff == htfd_pkg::POS_H_CRC) ? htfd_pkg::KIND_HUM
                                                         : htfd_pkg::KIND_TEMP;
    assign o_job.ok   = (crc_eff == i_data_byte);
    assign o_job.raw  = {r_high, r_low};

    // Next-state logic per byte position.
    always_comb begin
        n_pos  = r_pos;
        n_crc  = r_crc;
        n_high = r_high;
        n_low  = r_low;
        o_push = 1'b0;
        if (accept) begin
            unique case (pos_eff)
                htfd_pkg::POS_T_HIGH, htfd_pkg::POS_H_HIGH: begin
                    n_high = i_data_byte;
                    n_crc  = crc_next;
                    n_pos  = pos_eff + 3'd1;
                end
                htfd_pkg::POS_T_LOW, htfd_pkg::POS_H_LOW: begin
                    n_low = i_data_byte;
                    n_crc = crc_next;
                    n_pos = pos_eff + 3'd1;
                end
                htfd_pkg::POS_T_CRC, htfd_pkg::POS_H_CRC: begin
                    o_push = 1'b1;
                    n_crc  = htfd_pkg::CRC_INIT;
                    n_pos  = (pos_eff == htfd_pkg::POS_H_CRC) ? htfd_pkg::POS_T_HIGH
                                                              : htfd_pkg::POS_H_HIGH;
                end
                default: begin
                    n_pos = htfd_pkg::POS_T_HIGH;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= htfd_pkg::POS_T_HIGH;
            r_crc <= htfd_pkg::CRC_INIT;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    // Word bytes are always written before they are used.
    always_ff @(posedge i_clk) begin
        r_high <= n_high;
        r_low  <= n_low;
    end

endmodule

`default_nettype wire

>>> rtl/htfd_queue.sv
// Short queue of complete words between the front end and the back end.
// Depends on htfd_pkg for the word type and the queue depth.
`default_nettype none

module htfd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire htfd_pkg::t_job i_job,
    output logic                o_full,
    output logic                o_valid,
    output htfd_pkg::t_job      o_job,
    input  wire logic           i_pop
);

    htfd_pkg::t_job                   r_mem [htfd_pkg::QUEUE_DEPTH];
    logic [htfd_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [htfd_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [htfd_pkg::QCNT_W-1:0]      r_count;
    logic                             pop;

    localparam logic [htfd_pkg::QPTR_W-1:0] PTR_LAST =
        htfd_pkg::QPTR_W'(htfd_pkg::QUEUE_DEPTH - 1);
    localparam logic [htfd_pkg::QCNT_W-1:0] CNT_FULL =
        htfd_pkg::QCNT_W'(htfd_pkg::QUEUE_DEPTH);

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign pop     = i_pop & o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/htfd_back.sv
// Back end of the frame decoder: scales each word to hundredths in two stages
// and holds the result in the output register. Depends on htfd_pkg.
`default_nettype none

module htfd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire htfd_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic                o_measure_kind,
    output logic signed [15:0]  o_value,
    output logic                o_checksum_ok,
    output logic                o_last_of_frame
);

    logic        r_s1_valid;
    logic        r_s1_kind;
    logic        r_s1_ok;
    logic [30:0] r_s1_prod;

    logic        r_out_valid;
    logic        r_out_kind;
    logic        r_out_ok;
    logic [15:0] r_out_value;

    logic        out_free;
    logic        s1_free;
    logic [14:0] scale;
    logic [30:0] prod;
    logic [14:0] quo_hi;
    logic [16:0] fold;
    logic        wrap;
    logic [14:0] quo;
    logic        rem_nz;
    logic        below;
    logic [15:0] temp_val;
    logic [15:0] hum_val;
    logic [15:0] value;

    // Each stage moves on when the one after it is empty or emptying.
    assign out_free = ~r_out_valid | i_ready;
    assign s1_free  = ~r_s1_valid | out_free;
    assign o_pop    = s1_free;

    // Stage one: multiply the raw word by the span of its kind.
    assign scale = (i_job.kind == htfd_pkg::KIND_HUM) ? htfd_pkg::HUM_SPAN
                                                      : htfd_pkg::TEMP_SPAN;
    assign prod  = 31'(i_job.raw) * 31'(scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_valid) begin
            r_s1_kind <= i_job.kind;
            r_s1_ok   <= i_job.ok;
            r_s1_prod <= prod;
        end
    end

    // Stage two: divide by 65535 as p = a*65536 + b = a*65535 + (a + b),
    // where a + b stays below twice the divisor.
    assign quo_hi = r_s1_prod[30:16];
    assign fold   = {2'b00, quo_hi} + {1'b0, r_s1_prod[15:0]};
    assign wrap   = (fold >= htfd_pkg::RAW_FULL);
    assign quo    = quo_hi + {14'd0, wrap};
    assign rem_nz = wrap ? (fold != htfd_pkg::RAW_FULL) : (fold != 17'd0);

    // Below the offset the result is negative, and truncation toward zero
    // rounds the quotient up when there is a remainder.
    assign below    = ({1'b0, quo} < htfd_pkg::TEMP_OFFSET);
    assign temp_val = {1'b0, quo} - htfd_pkg::TEMP_OFFSET + {15'd0, below & rem_nz};
    assign hum_val  = {1'b0, quo};

    always_comb begin
        if (!r_s1_ok) begin
            value = (r_s1_kind == htfd_pkg::KIND_HUM) ? htfd_pkg::HUM_BAD
                                                      : htfd_pkg::TEMP_BAD;
        end else begin
            value = (r_s1_kind == htfd_pkg::KIND_HUM) ? hum_val : temp_val;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_kind  <= r_s1_kind;
            r_out_ok    <= r_s1_ok;
            r_out_value <= value;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_measure_kind  = r_out_kind;
    assign o_value         = $signed(r_out_value);
    assign o_checksum_ok   = r_out_ok;
    assign o_last_of_frame = (r_out_kind == htfd_pkg::KIND_HUM);

endmodule

`default_nettype wire

>>> rtl/humidity_temp_frame_decoder_core.sv
// Humidity and temperature reply decoder. The block takes the six-byte sensor
// reply one byte per transaction (temperature high, low, checksum, then
// humidity high, low, checksum), checks each word with CRC-8 (polynomial 0x31,
// seed 0xFF) and gives one result per word: the value in hundredths of degC
// or %RH, or -32768 / -1 when the checksum fails. A set frame_start marks the
// first byte and drops any partial reply; without it the position wraps after
// six bytes. One byte is taken every clock cycle; the input only stalls when
// the two-entry word queue is full because results are not being taken. After
// its checksum byte is accepted, a word passes through the word queue, the
// multiplier stage and the divide-by-65535 stage into the output register.
// Depends on htfd_pkg, htfd_front, htfd_queue and htfd_back.
`default_nettype none

module humidity_temp_frame_decoder_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_frame_start,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_measure_kind,
    output logic signed [15:0] o_value,
    output logic               o_checksum_ok,
    output logic               o_last_of_frame
);

    logic           q_full;
    logic           push;
    htfd_pkg::t_job push_job;
    logic           q_valid;
    htfd_pkg::t_job q_job;
    logic           q_pop;

    // Byte tracking and CRC.
    htfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    // Word queue.
    htfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    // Scaling and output register.
    htfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_job           (q_job),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_measure_kind  (o_measure_kind),
        .o_value         (o_value),
        .o_checksum_ok   (o_checksum_ok),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

`default_nettype wire

>>> rtl/htfd_checker.sv
// Port-level checks of the frame decoder's results, and the bind that
// attaches them to humidity_temp_frame_decoder_core. Depends on htfd_pkg.
`default_nettype none

module htfd_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               o_valid,
    input  wire logic               i_ready,
    input  wire logic               o_measure_kind,
    input  wire logic signed [15:0] o_value,
    input  wire logic               o_checksum_ok,
    input  wire logic               o_last_of_frame
);

    // A stalled result transaction keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value) && $stable(o_measure_kind))
        else $error("result changed while stalled");

    // Only the humidity word closes a frame.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_of_frame == o_measure_kind))
        else $error("last_of_frame disagrees with measure_kind");

    // A failed checksum always carries the sentinel of its kind.
    a_bad_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_checksum_ok |->
            ((o_measure_kind == htfd_pkg::KIND_HUM && o_value == -16'sd1) ||
             (o_measure_kind == htfd_pkg::KIND_TEMP && o_value == -16'sd32768)))
        else $error("checksum failure without sentinel");

    // A good word stays inside its scaled range.
    a_good_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_checksum_ok |->
            ((o_measure_kind == htfd_pkg::KIND_HUM && o_value >= 16'sd0 &&
              o_value <= 16'sd10000) ||
             (o_measure_kind == htfd_pkg::KIND_TEMP && o_value >= -16'sd4500 &&
              o_value <= 16'sd13000)))
        else $error("scaled value out of range");

endmodule

bind humidity_temp_frame_decoder_core htfd_checker u_htfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_measure_kind  (o_measure_kind),
    .o_value         (o_value),
    .o_checksum_ok   (o_checksum_ok),
    .o_last_of_frame (o_last_of_frame)
);

`default_nettype wire

>>> bench/tb_humidity_temp_frame_decoder_core.sv
`timescale 1ns / 100ps
// Self-checking bench for humidity_temp_frame_decoder_core: directed and random sensor
// replies are predicted byte by byte and every result is compared field by field.
// Depends on htfd_pkg and the decoder RTL only.

// One expected result of the decoder.
typedef struct {
    logic               kind;
    logic signed [15:0] hundredths;
    logic               crc_match;
    logic               ends_frame;
} t_reading;

// Tracks the reply position and CRC of the decoder and holds the readings still owed.
class reading_tracker;
    logic [2:0] position;
    logic [7:0] crc_acc;
    logic [7:0] high_byte;
    logic [7:0] low_byte;
    t_reading   awaited[$];
    int         mismatches;

    function new();
        position   = htfd_pkg::POS_T_HIGH;
        crc_acc    = htfd_pkg::CRC_INIT;
        high_byte  = '0;
        low_byte   = '0;
        mismatches = 0;
    endfunction

    // CRC-8 over one byte, fed one data bit at a time from the top.
    static function logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0};
            if (fb) begin
                r = r ^ htfd_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    // Temperature in hundredths, exact integer form truncated toward zero.
    static function logic signed [15:0] temp_hundredths(input logic [15:0] raw);
        longint span;
        longint offset;
        longint full;
        longint r;
        longint q;
        span   = htfd_pkg::TEMP_SPAN;
        offset = htfd_pkg::TEMP_OFFSET;
        full   = htfd_pkg::RAW_FULL;
        r      = raw;
        q      = (span * r - offset * full) / full;
        return q[15:0];
    endfunction

    // Relative humidity in hundredths, truncated.
    static function logic signed [15:0] hum_hundredths(input logic [15:0] raw);
        longint span;
        longint full;
        longint r;
        longint q;
        span = htfd_pkg::HUM_SPAN;
        full = htfd_pkg::RAW_FULL;
        r    = raw;
        q    = (span * r) / full;
        return q[15:0];
    endfunction

    // Notes one accepted byte and queues the reading it completes, if any.
    function void take_byte(input logic [7:0] b, input logic fs);
        t_reading    rd;
        logic [2:0]  pos;
        logic [15:0] raw;
        logic        match;
        pos = position;
        if (fs || pos > htfd_pkg::POS_H_CRC) begin
            pos     = htfd_pkg::POS_T_HIGH;
            crc_acc = htfd_pkg::CRC_INIT;
        end
        case (pos)
            htfd_pkg::POS_T_HIGH, htfd_pkg::POS_H_HIGH: begin
                high_byte = b;
                crc_acc   = crc8_step(crc_acc, b);
                position  = pos + 3'd1;
            end
            htfd_pkg::POS_T_LOW, htfd_pkg::POS_H_LOW: begin
                low_byte = b;
                crc_acc  = crc8_step(crc_acc, b);
                position = pos + 3'd1;
            end
            default: begin
                raw           = {high_byte, low_byte};
                match         = (crc_acc == b);
                rd.ends_frame = (pos == htfd_pkg::POS_H_CRC);
                rd.kind       = rd.ends_frame ? htfd_pkg::KIND_HUM : htfd_pkg::KIND_TEMP;
                rd.crc_match  = match;
                if (rd.kind == htfd_pkg::KIND_HUM) begin
                    rd.hundredths = match ? hum_hundredths(raw) : htfd_pkg::HUM_BAD;
                end else begin
                    rd.hundredths = match ? temp_hundredths(raw) : htfd_pkg::TEMP_BAD;
                end
                awaited.push_back(rd);
                crc_acc  = htfd_pkg::CRC_INIT;
                position = rd.ends_frame ? htfd_pkg::POS_T_HIGH : htfd_pkg::POS_H_HIGH;
            end
        endcase
    endfunction

    // Compares one accepted result with the oldest reading still owed.
    function void compare_reading(input logic kind, input logic signed [15:0] hundredths,
                                  input logic crc_match, input logic ends_frame);
        t_reading rd;
        if (awaited.size() == 0) begin
            $error("unexpected result: measure_kind %0d value %0d", kind, hundredths);
            mismatches++;
            return;
        end
        rd = awaited.pop_front();
        if (kind !== rd.kind) begin
            $error("measure_kind: expected %0d, got %0d", rd.kind, kind);
            mismatches++;
        end
        if (hundredths !== rd.hundredths) begin
            $error("value: expected %0d, got %0d", rd.hundredths, hundredths);
            mismatches++;
        end
        if (crc_match !== rd.crc_match) begin
            $error("checksum_ok: expected %0d, got %0d", rd.crc_match, crc_match);
            mismatches++;
        end
        if (ends_frame !== rd.ends_frame) begin
            $error("last_of_frame: expected %0d, got %0d", rd.ends_frame, ends_frame);
            mismatches++;
        end
    endfunction
endclass

module tb_humidity_temp_frame_decoder_core;

    localparam int QUIET_LIMIT = 2000;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic [7:0]         i_data_byte   = '0;
    logic               i_frame_start = 1'b0;
    logic               i_ready       = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic               o_measure_kind;
    logic signed [15:0] o_value;
    logic               o_checksum_ok;
    logic               o_last_of_frame;

    int send_idle_pct = 0;
    int sink_idle_pct = 0;
    int bytes_sent    = 0;
    int quiet_cycles  = 0;

    reading_tracker readings = new();

    humidity_temp_frame_decoder_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_frame_start   (i_frame_start),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_measure_kind  (o_measure_kind),
        .o_value         (o_value),
        .o_checksum_ok   (o_checksum_ok),
        .o_last_of_frame (o_last_of_frame)
    );

    always #1 i_clk = ~i_clk;

    // Result side stalls at random according to the current phase.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Both channels are observed here; a long spell without any transaction ends the run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                readings.take_byte(i_data_byte, i_frame_start);
            end
            if (o_valid && i_ready) begin
                readings.compare_reading(o_measure_kind, o_value, o_checksum_ok,
                                         o_last_of_frame);
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offers one byte after an optional random gap and returns once it is accepted.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_data_byte   <= b;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    // Sends a full reply; a set bad flag spoils that word's checksum byte.
    task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                              input logic t_bad, input logic h_bad, input logic marked);
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        t_crc = readings.crc8_step(readings.crc8_step(htfd_pkg::CRC_INIT, t_raw[15:8]),
                                   t_raw[7:0]) ^ {7'd0, t_bad};
        h_crc = readings.crc8_step(readings.crc8_step(htfd_pkg::CRC_INIT, h_raw[15:8]),
                                   h_raw[7:0]) ^ {7'd0, h_bad};
        send_byte(t_raw[15:8], marked);
        send_byte(t_raw[7:0], 1'b0);
        send_byte(t_crc, 1'b0);
        send_byte(h_raw[15:8], 1'b0);
        send_byte(h_raw[7:0], 1'b0);
        send_byte(h_crc, 1'b0);
    endtask

    // Holds the input idle until every owed reading has been taken.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (readings.awaited.size() != 0);
    endtask

    // Raw words lean towards the two ends of the scale.
    function automatic logic [15:0] random_raw();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            return 16'h0000;
        end else if (pick == 1) begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(16'hFFFF));
    endfunction

    // Mostly well-formed replies, with some cut-short replies and loose noise bytes.
    task automatic run_random(input int target);
        int first;
        int pick;
        int n;
        first = bytes_sent;
        while (bytes_sent - first < target) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_frame(random_raw(), random_raw(), $urandom_range(9) == 0,
                           $urandom_range(9) == 0, $urandom_range(3) != 0);
            end else if (pick < 90) begin
                n = $urandom_range(1, 5);
                send_byte(8'($urandom), 1'b1);
                repeat (n - 1) send_byte(8'($urandom), 1'b0);
            end else begin
                n = $urandom_range(1, 8);
                repeat (n) send_byte(8'($urandom), $urandom_range(3) == 0);
            end
            if ($urandom_range(49) == 0) begin
                wait_for_results();
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full-scale temperature with zero humidity, then the reverse with no frame marker.
        send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1);
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        // A reply cut short by a new frame start, which itself fails both checksums.
        send_byte(8'hBE, 1'b1);
        send_byte(8'hEF, 1'b0);
        send_frame(16'h6666, 16'h8000, 1'b1, 1'b1, 1'b1);
        wait_for_results();

        // Random replies under three idling patterns.
        send_idle_pct = 38;
        sink_idle_pct = 45;
        run_random(400);
        wait_for_results();
        send_idle_pct = 45;
        sink_idle_pct = 38;
        run_random(400);
        wait_for_results();
        send_idle_pct = 0;
        sink_idle_pct = 0;
        run_random(400);
        wait_for_results();

        repeat (10) @(posedge i_clk);
        if (readings.mismatches == 0 && readings.awaited.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
